### rtl/cda_pkg.sv
// shared types, codes and calendar helpers for the date adder
package cda_pkg;

	// operation codes
	localparam logic [1:0] FUNC_DAY   = 2'd0;
	localparam logic [1:0] FUNC_WEEK  = 2'd1;
	localparam logic [1:0] FUNC_MONTH = 2'd2;

	// month numbers with special handling
	localparam logic [3:0] MON_JAN = 4'd1;
	localparam logic [3:0] MON_FEB = 4'd2;
	localparam logic [3:0] MON_DEC = 4'd12;

	// days in each month of a common year, January first
	localparam logic [4:0] MONTH_LEN [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	localparam logic [4:0] FEB_LEAP   = 5'd29;
	localparam logic [4:0] FEB_COMMON = 5'd28;
	localparam logic [4:0] DAY_MAX    = 5'd31;
	localparam logic [5:0] WEEK_DAYS  = 6'd7;

	// 16-bit year divided by 100 as (year / 4) / 25:
	// q = ((y & ~3) * 5243) >> 19, exact for every 16-bit year
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          RECIP_SHFT = 19;
	localparam logic [6:0]  CENT_LAST  = 7'd99;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic div;
		logic rem;
		logic clamp;
		logic step_day;
		logic step_week;
		logic step_month;
		logic out_load;
	} cda_cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic       cnt_zero;
		logic [1:0] func;
	} cda_sts_t;

	// length of a month, zero for a month number outside 1..12
	function automatic logic [4:0] month_days(input logic [3:0] month, input logic leap);
		logic [4:0] d;
		begin
			if (month == MON_FEB) begin
				d = leap ? FEB_LEAP : FEB_COMMON;
			end else if (month >= MON_JAN && month <= MON_DEC) begin
				d = MONTH_LEN[month - 4'd1];
			end else begin
				d = 5'd0;
			end
			return d;
		end
	endfunction

endpackage

### rtl/cda_if.sv
// request and result channel interfaces of the date adder

// request channel: starting date, operation and repeat count
interface cda_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	logic [4:0]  day_in;
	logic [3:0]  month_in;
	logic [15:0] year_in;
	logic [14:0] count;

	modport source (output valid, output func, output day_in, output month_in,
		output year_in, output count, input ready);
	modport sink (input valid, input func, input day_in, input month_in,
		input year_in, input count, output ready);
endinterface

// result channel: advanced date
interface cda_rsp_if;
	logic        valid;
	logic        ready;
	logic [4:0]  day_out;
	logic [3:0]  month_out;
	logic [15:0] year_out;

	modport source (output valid, output day_out, output month_out, output year_out,
		input ready);
	modport sink (input valid, input day_out, input month_out, input year_out,
		output ready);
endinterface

### rtl/calendar_date_adder_top.sv
// top level of the gregorian date adder
// One request at a time: a request is taken in the idle state and its result
// is written to an output register, which holds it until taken while the next
// request is already accepted. Setup states split the year by 100 (one
// reciprocal multiply, one back-multiply) and clamp the day; then the date step
// unit applies one day or one week per cycle for day and week operations until
// the count is used up, or a single month step, or no step for an unused code.
module calendar_date_adder_top (
	input logic      clk,
	input logic      arst_n,
	cda_req_if.sink  req,
	cda_rsp_if.source rsp
);

	cda_pkg::cda_cmd_t cmd;
	cda_pkg::cda_sts_t sts;

	// sequencing
	cda_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// date registers and step logic
	cda_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.func      (req.func),
		.day_in    (req.day_in),
		.month_in  (req.month_in),
		.year_in   (req.year_in),
		.count     (req.count),
		.day_out   (rsp.day_out),
		.month_out (rsp.month_out),
		.year_out  (rsp.year_out)
	);

endmodule

### rtl/cda_dp.sv
// datapath of the date adder: date registers, leap tracking, step logic, result register
module cda_dp (
	input  logic              clk,
	input  logic              arst_n,
	input  cda_pkg::cda_cmd_t cmd,
	output cda_pkg::cda_sts_t sts,
	input  logic [1:0]        func,
	input  logic [4:0]        day_in,
	input  logic [3:0]        month_in,
	input  logic [15:0]       year_in,
	input  logic [14:0]       count,
	output logic [4:0]        day_out,
	output logic [3:0]        month_out,
	output logic [15:0]       year_out
);

	logic [1:0]  func_q;
	logic [4:0]  day_q;
	logic [3:0]  month_q;
	logic [15:0] year_q;
	logic [14:0] cnt_q;
	logic [9:0]  quot_q;
	logic [6:0]  r100_q;
	logic [1:0]  c4_q;
	logic [4:0]  day_out_q;
	logic [3:0]  month_out_q;
	logic [15:0] year_out_q;

	logic        leap;
	logic [4:0]  len;
	logic [4:0]  feb_len;
	logic        dec;
	logic [3:0]  mon_inc;
	logic [5:0]  day_p7;
	logic [5:0]  day_wk;
	logic [28:0] prod;
	logic [15:0] cent_sub;
	logic [15:0] rem_full;
	logic [4:0]  day_nx;
	logic [3:0]  mon_nx;
	logic        yr_step;
	logic        stepping;
	logic [15:0] yr_inc;
	logic [6:0]  r100_nx;
	logic [1:0]  c4_nx;

	// leap flag from the year's remainders by 4, 100 and 400
	assign leap = ((year_q[1:0] == 2'd0) && (r100_q != 7'd0)) ||
		((r100_q == 7'd0) && (c4_q == 2'd0));

	// month lengths and neighbors of the current date
	assign len     = cda_pkg::month_days(month_q, leap);
	assign feb_len = leap ? cda_pkg::FEB_LEAP : cda_pkg::FEB_COMMON;
	assign dec     = (month_q == cda_pkg::MON_DEC);
	assign mon_inc = month_q + 4'd1;
	assign day_p7  = {1'b0, day_q} + cda_pkg::WEEK_DAYS;
	assign day_wk  = day_p7 - {1'b0, len};

	// year divided by 100 through the reciprocal, remainder by back-multiply
	assign prod     = {16'd0, cda_pkg::RECIP_100} * {13'd0, year_q[15:2], 2'b00};
	assign cent_sub = {6'd0, quot_q} * 16'd100;
	assign rem_full = year_q - cent_sub;

	// next year and its remainders when the date rolls into january
	assign yr_inc = year_q + 16'd1;
	always_comb begin
		if (year_q == 16'hFFFF) begin
			r100_nx = 7'd0;
			c4_nx   = 2'd0;
		end else if (r100_q == cda_pkg::CENT_LAST) begin
			r100_nx = 7'd0;
			c4_nx   = c4_q + 2'd1;
		end else begin
			r100_nx = r100_q + 7'd1;
			c4_nx   = c4_q;
		end
	end

	// one day, week or month step
	always_comb begin
		day_nx  = day_q;
		mon_nx  = month_q;
		yr_step = 1'b0;
		if (cmd.step_day) begin
			if (day_q >= len) begin
				day_nx  = 5'd1;
				mon_nx  = dec ? cda_pkg::MON_JAN : mon_inc;
				yr_step = dec;
			end else begin
				day_nx = day_q + 5'd1;
			end
		end else if (cmd.step_week) begin
			if (day_p7 > {1'b0, len}) begin
				day_nx  = day_wk[4:0];
				mon_nx  = dec ? cda_pkg::MON_JAN : mon_inc;
				yr_step = dec;
			end else begin
				day_nx = day_p7[4:0];
			end
		end else if (cmd.step_month) begin
			if (dec) begin
				mon_nx  = cda_pkg::MON_JAN;
				yr_step = 1'b1;
				if (day_q == len) begin
					day_nx = cda_pkg::DAY_MAX;
				end
			end else if (month_q == cda_pkg::MON_JAN) begin
				mon_nx = cda_pkg::MON_FEB;
				if (day_q > feb_len) begin
					day_nx = feb_len;
				end
			end else begin
				mon_nx = mon_inc;
				if (day_q == len) begin
					day_nx = cda_pkg::month_days(mon_inc, leap);
				end
			end
		end
	end

	assign stepping = cmd.step_day || cmd.step_week || cmd.step_month;

	// date, count and remainder registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			day_q   <= (day_in == 5'd0) ? 5'd1 : day_in;
			month_q <= (month_in == 4'd0) ? cda_pkg::MON_JAN :
				((month_in > cda_pkg::MON_DEC) ? cda_pkg::MON_DEC : month_in);
			year_q  <= year_in;
			cnt_q   <= count;
		end
		if (cmd.div) begin
			quot_q <= prod[cda_pkg::RECIP_SHFT +: 10];
		end
		if (cmd.rem) begin
			r100_q <= rem_full[6:0];
			c4_q   <= quot_q[1:0];
		end
		if (cmd.clamp && (day_q > len)) begin
			day_q <= len;
		end
		if (stepping) begin
			day_q   <= day_nx;
			month_q <= mon_nx;
			if (yr_step) begin
				year_q <= yr_inc;
				r100_q <= r100_nx;
				c4_q   <= c4_nx;
			end
		end
		if (cmd.step_day || cmd.step_week) begin
			cnt_q <= cnt_q - 15'd1;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			day_out_q   <= day_q;
			month_out_q <= month_q;
			year_out_q  <= year_q;
		end
	end

	assign sts.cnt_zero = (cnt_q == 15'd0);
	assign sts.func     = func_q;
	assign day_out      = day_out_q;
	assign month_out    = month_out_q;
	assign year_out     = year_out_q;

	// the date stays a legal date while it is being stepped
	a_day_legal: assert property (@(posedge clk) disable iff (!arst_n)
		stepping |-> (day_q >= 5'd1) && (day_q <= len))
		else $error("day outside its month during a step");
	a_month_legal: assert property (@(posedge clk) disable iff (!arst_n)
		stepping |-> (month_q >= cda_pkg::MON_JAN) && (month_q <= cda_pkg::MON_DEC))
		else $error("month out of range during a step");
	a_rem_legal: assert property (@(posedge clk) disable iff (!arst_n)
		stepping |-> (r100_q <= cda_pkg::CENT_LAST))
		else $error("year remainder by 100 out of range");

endmodule

### rtl/cda_ctrl.sv
// controller of the date adder: sequencing and handshakes
module cda_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output cda_pkg::cda_cmd_t cmd,
	input  cda_pkg::cda_sts_t sts
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV   = 3'd1;
	localparam logic [2:0] ST_REM   = 3'd2;
	localparam logic [2:0] ST_CLAMP = 3'd3;
	localparam logic [2:0] ST_RUN   = 3'd4;
	localparam logic [2:0] ST_FIN   = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || out_ready;

	// next state and commands
	always_comb begin
		state_nx = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_nx = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div  = 1'b1;
				state_nx = ST_REM;
			end
			ST_REM: begin
				cmd.rem  = 1'b1;
				state_nx = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.clamp = 1'b1;
				state_nx  = ST_RUN;
			end
			ST_RUN: begin
				if (sts.func == cda_pkg::FUNC_DAY && !sts.cnt_zero) begin
					cmd.step_day = 1'b1;
				end else if (sts.func == cda_pkg::FUNC_WEEK && !sts.cnt_zero) begin
					cmd.step_week = 1'b1;
				end else if (sts.func == cda_pkg::FUNC_MONTH) begin
					cmd.step_month = 1'b1;
					state_nx       = ST_FIN;
				end else begin
					state_nx = ST_FIN;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_nx     = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	// an accepted request starts the year split
	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIV))
		else $error("accepted request did not start processing");
	// a finished date reaches the result register once that register is free
	a_fin_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && out_free) |=> (out_valid_q && state_q == ST_IDLE))
		else $error("finished date not presented");
	// a month step is a single step
	a_month_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step_month |=> (state_q == ST_FIN))
		else $error("month step repeated");

endmodule
